/* rtl/pwfe_pkg.sv */
// Shared types and constants of the pulse width frame encoder.
package pwfe_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_HOUSE_ONE = 2'd0;
   localparam logic [1:0] CSR_HOUSE_TWO = 2'd1;
   localparam logic [1:0] CSR_PRE_EN    = 2'd2;

   // Request kind carried on req_tuser
   localparam logic CMD_RAW       = 1'b0;
   localparam logic CMD_VALVE_SET = 1'b1;

   // Fixed frame bytes
   localparam logic [7:0] PRE_PREAMBLE_BYTE = 8'haa;
   localparam logic [7:0] PREAMBLE_BYTE     = 8'hcc;
   localparam logic [7:0] TERMINATOR_BYTE   = 8'hff;
   localparam logic [7:0] VALVE_SET_CMD     = 8'h26;
   localparam logic [7:0] CHECKSUM_SEED     = 8'h0c;
   localparam logic [7:0] ASSEMBLY_EMPTY    = 8'hff;

   // Byte counts
   localparam logic [3:0] PREAMBLE_COUNT = 4'd6;
   localparam logic [3:0] PRE_AND_PREAMBLE_COUNT = 4'd10;
   localparam logic [5:0] FRAME_MAX = 6'd51;

   // Percent scaling: floor(p*255/100) == (p*EXT_SCALE) >> 19 for p <= 100
   localparam logic [6:0]  PERCENT_MAX = 7'd100;
   localparam logic [20:0] EXT_SCALE   = 21'd1336965;

   // Logical bit positions: start bit, six bytes of nine bits, two stop zeros
   localparam logic [5:0] POS_BODY_FIRST = 6'd1;
   localparam logic [5:0] POS_BODY_LAST  = 6'd54;
   localparam logic [5:0] POS_DONE       = 6'd57;
   localparam logic [3:0] PARITY_SLOT    = 4'd8;

   // Body byte order
   localparam logic [2:0] BYTE_HOUSE_TWO = 3'd1;
   localparam logic [2:0] BYTE_ADDRESS   = 3'd2;
   localparam logic [2:0] BYTE_COMMAND   = 3'd3;
   localparam logic [2:0] BYTE_EXTENSION = 3'd4;

   // Line code pairs
   localparam logic [1:0] PAIR_HIGH = 2'b11;
   localparam logic [1:0] PAIR_MID  = 2'b10;
   localparam logic [1:0] PAIR_LOW  = 2'b00;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PRE,
      ST_BITS,
      ST_TERM
   } state_type;

   // Bit source to top
   typedef struct packed {
      logic bit_val;
      logic done;
   } src_status_type;

   // Line coder to top
   typedef struct packed {
      logic       bit_done;
      logic       byte_valid;
      logic [7:0] byte_val;
   } coder_status_type;

endpackage

/* rtl/pwfe_bit_source.sv */
// Serializes the frame body into logical bits with parity and checksum.
module pwfe_bit_source import pwfe_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic           advance,
   input  logic [7:0]     house_one,
   input  logic [7:0]     house_two,
   input  logic [7:0]     address,
   input  logic [7:0]     command_byte,
   input  logic [7:0]     extension,
   output src_status_type status
);

   logic [5:0] pos_ff, pos_in;
   logic [7:0] shift_ff, shift_in;
   logic       par_ff, par_in;
   logic [7:0] csum_ff, csum_in;
   logic [3:0] bit_ff, bit_in;
   logic [2:0] byte_ff, byte_in;
   logic [2:0] byte_nx;
   logic [7:0] next_byte;
   logic       in_body;
   logic       done;

   assign in_body = (pos_ff >= POS_BODY_FIRST) && (pos_ff <= POS_BODY_LAST);
   assign done    = (pos_ff == POS_DONE);
   assign byte_nx = byte_ff + 3'd1;

   // Byte that follows the current one; the checksum comes last
   always_comb begin
      case (byte_nx)
         BYTE_HOUSE_TWO: next_byte = house_two;
         BYTE_ADDRESS:   next_byte = address;
         BYTE_COMMAND:   next_byte = command_byte;
         BYTE_EXTENSION: next_byte = extension;
         default:        next_byte = csum_ff;
      endcase
   end

   // Current logical bit
   always_comb begin
      status.done = done;
      if (pos_ff == 6'd0) begin
         status.bit_val = 1'b1;
      end else if (in_body) begin
         status.bit_val = (bit_ff == PARITY_SLOT) ? par_ff : shift_ff[7];
      end else begin
         status.bit_val = 1'b0;
      end
   end

   // Shift, parity and checksum update
   always_comb begin
      pos_in   = pos_ff;
      shift_in = shift_ff;
      par_in   = par_ff;
      csum_in  = csum_ff;
      bit_in   = bit_ff;
      byte_in  = byte_ff;
      if (start) begin
         pos_in   = '0;
         shift_in = house_one;
         par_in   = 1'b0;
         csum_in  = CHECKSUM_SEED + house_one;
         bit_in   = '0;
         byte_in  = '0;
      end else if (advance && !done) begin
         pos_in = pos_ff + 6'd1;
         if (in_body) begin
            if (bit_ff == PARITY_SLOT) begin
               bit_in   = '0;
               par_in   = 1'b0;
               byte_in  = byte_nx;
               shift_in = next_byte;
               if (byte_nx <= BYTE_EXTENSION) begin
                  csum_in = csum_ff + next_byte;
               end
            end else begin
               par_in   = par_ff ^ shift_ff[7];
               shift_in = {shift_ff[6:0], 1'b0};
               bit_in   = bit_ff + 4'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_DONE;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      par_ff   <= par_in;
      csum_ff  <= csum_in;
      bit_ff   <= bit_in;
      byte_ff  <= byte_in;
   end

endmodule

/* rtl/pwfe_line_coder.sv */
// Line codes logical bits into bit pairs and gathers them into bytes.
module pwfe_line_coder import pwfe_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             clear,
   input  logic             step,
   input  logic             bit_val,
   output coder_status_type status
);

   logic [1:0] phase_ff, phase_in;
   logic [7:0] asm_ff, asm_in;
   logic [1:0] left_ff, left_in;
   logic [1:0] pair;
   logic [7:0] shifted;
   logic       bit_end;

   // Pair for this phase: a zero is 11 00, a one is 11 10 00
   always_comb begin
      case (phase_ff)
         2'd0:    pair = PAIR_HIGH;
         2'd1:    pair = bit_val ? PAIR_MID : PAIR_LOW;
         default: pair = PAIR_LOW;
      endcase
   end

   assign shifted = {asm_ff[5:0], pair};
   assign bit_end = ((phase_ff == 2'd1) && !bit_val) || (phase_ff == 2'd2);

   always_comb begin
      status.bit_done   = step && bit_end;
      status.byte_valid = step && (left_ff == 2'd0);
      status.byte_val   = shifted;
   end

   always_comb begin
      phase_in = phase_ff;
      asm_in   = asm_ff;
      left_in  = left_ff;
      if (clear) begin
         phase_in = '0;
         asm_in   = ASSEMBLY_EMPTY;
         left_in  = 2'd3;
      end else if (step) begin
         phase_in = bit_end ? 2'd0 : phase_ff + 2'd1;
         if (left_ff == 2'd0) begin
            asm_in  = ASSEMBLY_EMPTY;
            left_in = 2'd3;
         end else begin
            asm_in  = shifted;
            left_in = left_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         asm_ff   <= ASSEMBLY_EMPTY;
         left_ff  <= 2'd3;
      end else begin
         phase_ff <= phase_in;
         asm_ff   <= asm_in;
         left_ff  <= left_in;
      end
   end

endmodule

/* rtl/pulse_width_frame_encoder.sv */
// Top level of the pulse width frame encoder: request capture, sequencing, output word.
//
// One request word on req_ in gives one complete radio frame as a run of byte words
// on rsp_, sent most significant bit first on air; the terminator 0xff carries
// rsp_tlast. The house codes and the pre-preamble enable are set on the csr_ port;
// the user must write them only while no frame is in flight; the block does not
// enforce it. req_tready is high only while no frame is in progress. After a request
// is accepted the sequencer enters ST_PRE and loads each preamble byte into the
// output word register once the output slot is free; the body is built one coded bit
// pair per cycle in the line coder while the receiver does not stall, and each four
// pairs make one body byte. A stalled receiver freezes the sequencer: nothing
// advances while the output word waits, and no word is lost or repeated.
// Reset is synchronous and active high; it clears the sequencer and the output
// valid and sets the house codes to 0xff and the pre-preamble enable to 0.
module pulse_width_frame_encoder import pwfe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // command_code[7:0], extension_byte[15:8],
                                    // percent_open[22:16], valve_address[30:23]
   input  logic        req_tuser,   // command
   // Response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // tx_byte[7:0]
   output logic        rsp_tlast,   // last_byte
   // Configuration port
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   state_type state_ff, state_in;

   logic [7:0] house_one_ff, house_two_ff;
   logic       pre_en_ff;
   logic [7:0] addr_ff, cmd_ff, ext_ff;
   logic [7:0] addr_in, cmd_in, ext_in;
   logic [3:0] pre_cnt_ff, pre_cnt_in;
   logic [5:0] frame_cnt_ff, frame_cnt_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic       rsp_last_ff, rsp_last_in;

   logic       accept;
   logic       slot_free;
   logic       emit_ok;
   logic       out_load;
   logic [7:0] out_byte;
   logic       out_last;
   logic       step;

   logic [6:0]  pct_sat;
   logic [27:0] ext_prod;
   logic        want_pre;

   src_status_type   src;
   coder_status_type coder;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign emit_ok    = (frame_cnt_ff < FRAME_MAX);

   // Valve-set extension byte and pre-preamble decision
   always_comb begin
      pct_sat  = (req_tdata[22:16] > PERCENT_MAX) ? PERCENT_MAX : req_tdata[22:16];
      ext_prod = {21'd0, pct_sat} * {7'd0, EXT_SCALE};
      want_pre = req_tuser && (pct_sat != 7'd0) && pre_en_ff;
   end

   // Request capture
   always_comb begin
      addr_in = addr_ff;
      cmd_in  = cmd_ff;
      ext_in  = ext_ff;
      if (accept) begin
         addr_in = req_tdata[30:23];
         cmd_in  = req_tuser ? VALVE_SET_CMD : req_tdata[7:0];
         ext_in  = req_tuser ? ext_prod[26:19] : req_tdata[15:8];
      end
   end

   assign step = (state_ff == ST_BITS) && slot_free && !src.done;

   pwfe_bit_source u_src (
      .clock        (clock),
      .reset        (reset),
      .start        (accept),
      .advance      (coder.bit_done),
      .house_one    (house_one_ff),
      .house_two    (house_two_ff),
      .address      (addr_ff),
      .command_byte (cmd_ff),
      .extension    (ext_ff),
      .status       (src)
   );

   pwfe_line_coder u_coder (
      .clock   (clock),
      .reset   (reset),
      .clear   (accept),
      .step    (step),
      .bit_val (src.bit_val),
      .status  (coder)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_PRE;
         end
         ST_PRE: begin
            if (slot_free && (pre_cnt_ff == 4'd1)) state_in = ST_BITS;
         end
         ST_BITS: begin
            if (src.done) state_in = ST_TERM;
         end
         ST_TERM: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      out_load = 1'b0;
      out_byte = TERMINATOR_BYTE;
      out_last = 1'b0;
      case (state_ff)
         ST_PRE: begin
            out_load = slot_free;
            out_byte = (pre_cnt_ff > PREAMBLE_COUNT) ? PRE_PREAMBLE_BYTE : PREAMBLE_BYTE;
         end
         ST_BITS: begin
            out_load = coder.byte_valid;
            out_byte = coder.byte_val;
         end
         ST_TERM: begin
            out_load = slot_free;
            out_byte = TERMINATOR_BYTE;
            out_last = 1'b1;
         end
         default: out_load = 1'b0;
      endcase
   end

   // Counters
   always_comb begin
      pre_cnt_in   = pre_cnt_ff;
      frame_cnt_in = frame_cnt_ff;
      if (accept) begin
         pre_cnt_in   = want_pre ? PRE_AND_PREAMBLE_COUNT : PREAMBLE_COUNT;
         frame_cnt_in = '0;
      end else begin
         if ((state_ff == ST_PRE) && slot_free) pre_cnt_in = pre_cnt_ff - 4'd1;
         if (out_load && emit_ok) frame_cnt_in = frame_cnt_ff + 6'd1;
      end
   end

   // Output word register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_load && emit_ok) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = out_byte;
         rsp_last_in  = out_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pre_cnt_ff   <= '0;
         frame_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pre_cnt_ff   <= pre_cnt_in;
         frame_cnt_ff <= frame_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      cmd_ff      <= cmd_in;
      ext_ff      <= ext_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         house_one_ff <= 8'hff;
         house_two_ff <= 8'hff;
         pre_en_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HOUSE_ONE: house_one_ff <= csr_wdata;
            CSR_HOUSE_TWO: house_two_ff <= csr_wdata;
            CSR_PRE_EN:    pre_en_ff    <= csr_wdata[0];
            default:       pre_en_ff    <= pre_en_ff;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Checks
   a_last_is_term: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata == TERMINATOR_BYTE))
      else $error("last word is not the terminator");

   a_frame_bound: assert property (@(posedge clock) disable iff (reset)
      frame_cnt_ff <= FRAME_MAX)
      else $error("frame byte count beyond bound");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("request taken while frame still in progress");

   a_term_after_body: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TERM) |-> src.done)
      else $error("terminator before body finished");

endmodule
